// File: design/bfsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfsp_pkg;

    localparam int NODE_W        = 5;
    localparam int WEIGHT_W      = 16;
    localparam int DIST_W        = 32;
    localparam int NODE_COUNT_W  = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;

    localparam int DEF_MAX_NODES = 32;
    localparam int DEF_MAX_EDGES = 256;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'd1;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 6'd5;
    localparam logic [NODE_W-1:0]       SOURCE_RST     = 5'd0;

    typedef logic signed [DIST_W-1:0] t_dist;

    typedef struct packed {
        logic [NODE_W-1:0]          tail;
        logic [NODE_W-1:0]          head;
        logic signed [WEIGHT_W-1:0] weight;
    } t_edge;

endpackage

`default_nettype wire

// File: design/bellman_ford_shortest_paths_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Loading: a directed edge is written when taken; an undirected one also writes its
// reverse in a second state; busy stays low between plain edges. Compute starts after
// the edge flagged last: an init step, then n passes (n-1 relaxing, one check); each
// edge is a read of the edge memory then the distance memory, plus an add and update
// when not skipped. Results: n strobes on consecutive cycles, registered from the emit
// state after the last pass (after init when the source is out of range). Reset is
// synchronous; it empties the edge table; the receiver cannot stall results.

module bellman_ford_shortest_paths_unit #(
    parameter int MAX_NODES = bfsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = bfsp_pkg::DEF_MAX_EDGES
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       start,
    output logic                                      busy,
    input  wire [bfsp_pkg::NODE_W-1:0]                i_from_node,
    input  wire [bfsp_pkg::NODE_W-1:0]                i_to_node,
    input  wire signed [bfsp_pkg::WEIGHT_W-1:0]       i_weight,
    input  wire                                       i_undirected,
    input  wire                                       i_last_edge,
    input  wire                                       i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire [bfsp_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  wire [bfsp_pkg::CFG_DATA_W-1:0]            i_cfg_data,
    output logic                                      o_valid,
    output logic [bfsp_pkg::NODE_W-1:0]               o_node_index,
    output logic signed [bfsp_pkg::DIST_W-1:0]        o_distance,
    output logic                                      o_reachable,
    output logic                                      o_negative_cycle,
    output logic                                      o_edge_overflow,
    output logic                                      o_last_node
);

    localparam int NIW  = $clog2(MAX_NODES);
    localparam int CNTW = ($clog2(MAX_NODES + 1) > bfsp_pkg::NODE_COUNT_W)
                        ? $clog2(MAX_NODES + 1) : bfsp_pkg::NODE_COUNT_W;
    localparam int EIW  = $clog2(MAX_EDGES);
    localparam int ETW  = $clog2(MAX_EDGES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REV   = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DIST  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [bfsp_pkg::NODE_COUNT_W-1:0]   r_node_count;
    logic [bfsp_pkg::NODE_W-1:0]         r_source;
    logic [ETW-1:0]                      r_edge_total;
    logic                                r_overflow;
    logic [ETW-1:0]                      r_eidx;
    logic [CNTW-1:0]                     r_pass;
    logic                                r_neg;
    logic [MAX_NODES-1:0]                r_reached;
    logic [NIW-1:0]                      r_idx;
    logic                                r_out_valid;

    bfsp_pkg::t_edge                     edge_mem [MAX_EDGES];
    bfsp_pkg::t_dist                     dist_mem [MAX_NODES];
    bfsp_pkg::t_edge                     r_edge_rd;
    bfsp_pkg::t_edge                     r_rev_edge;
    logic                                r_rev_last;
    bfsp_pkg::t_dist                     r_dist_a;
    bfsp_pkg::t_dist                     r_dist_b;
    logic [NIW-1:0]                      r_out_idx;
    logic                                r_out_reach;
    logic                                r_out_neg;
    logic                                r_out_ovf;
    logic                                r_out_last;

    logic [CNTW-1:0]                     act_n;
    logic [CNTW-1:0]                     nc_ext;
    logic                                accept;
    logic                                in_ok;
    logic                                table_full;
    logic                                wr_req;
    logic                                edge_we;
    bfsp_pkg::t_edge                     edge_wdata;
    logic [NIW-1:0]                      tail_idx;
    logic [NIW-1:0]                      head_idx;
    logic [NIW-1:0]                      src_idx;
    logic                                src_ok;
    logic                                skip;
    logic                                last_pass;
    logic                                idx_last;
    logic                                pass_end;
    logic [NIW-1:0]                      rd_a_addr;
    logic                                rd_en;
    bfsp_pkg::t_dist                     cand;
    logic                                improve;

    // active node count: zero counts as one, clamp to capacity
    always_comb begin
        nc_ext = CNTW'(r_node_count);
        if (nc_ext == '0) begin
            act_n = CNTW'(1);
        end else if (nc_ext > CNTW'(MAX_NODES)) begin
            act_n = CNTW'(MAX_NODES);
        end else begin
            act_n = nc_ext;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign in_ok       = (CNTW'(i_from_node) < act_n) && (CNTW'(i_to_node) < act_n);
    assign table_full  = (r_edge_total == ETW'(MAX_EDGES));
    assign wr_req      = ((r_state == S_IDLE) && accept && in_ok) || (r_state == S_REV);
    assign edge_we     = wr_req && !table_full;
    assign edge_wdata  = (r_state == S_REV) ? r_rev_edge
                       : bfsp_pkg::t_edge'{tail: i_from_node, head: i_to_node,
                                           weight: i_weight};

    assign tail_idx  = NIW'(r_edge_rd.tail);
    assign head_idx  = NIW'(r_edge_rd.head);
    assign src_idx   = NIW'(r_source);
    assign src_ok    = CNTW'(r_source) < act_n;
    assign skip      = !(CNTW'(r_edge_rd.tail) < act_n) || !(CNTW'(r_edge_rd.head) < act_n)
                     || !r_reached[tail_idx];
    assign last_pass = (r_pass + CNTW'(1)) == act_n;
    assign idx_last  = (CNTW'(r_idx) + CNTW'(1)) == act_n;
    assign pass_end  = (r_eidx == r_edge_total);
    assign rd_a_addr = (r_state == S_EMIT) ? r_idx : tail_idx;
    assign rd_en     = (r_state == S_DIST) || (r_state == S_EMIT);

    bfsp_relax u_relax (
        .i_clk          (i_clk),
        .i_load         (r_state == S_ADD),
        .i_tail_dist    (r_dist_a),
        .i_weight       (r_edge_rd.weight),
        .i_head_dist    (r_dist_b),
        .i_head_reached (r_reached[head_idx]),
        .o_cand         (cand),
        .o_improve      (improve)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_ok && i_undirected) begin
                        n_state = S_REV;
                    end else if (i_last_edge) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_REV:   n_state = r_rev_last ? S_INIT : S_IDLE;
            S_INIT:  n_state = src_ok ? S_FETCH : S_EMIT;
            S_FETCH: begin
                if (pass_end) begin
                    n_state = last_pass ? S_EMIT : S_FETCH;
                end else begin
                    n_state = S_DIST;
                end
            end
            S_DIST:  n_state = skip ? S_FETCH : S_ADD;
            S_ADD:   n_state = S_UPD;
            S_UPD:   n_state = S_FETCH;
            S_EMIT:  n_state = idx_last ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= bfsp_pkg::NODE_COUNT_RST;
            r_source     <= bfsp_pkg::SOURCE_RST;
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_eidx       <= '0;
            r_pass       <= '0;
            r_neg        <= 1'b0;
            r_reached    <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_EMIT);

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bfsp_pkg::REG_NODE_COUNT:
                        r_node_count <= i_cfg_data[bfsp_pkg::NODE_COUNT_W-1:0];
                    bfsp_pkg::REG_SOURCE_NODE:
                        r_source <= i_cfg_data[bfsp_pkg::NODE_W-1:0];
                    default: ;
                endcase
            end

            if (wr_req) begin
                if (table_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_edge_total <= r_edge_total + ETW'(1);
                end
            end

            unique case (r_state)
                S_INIT: begin
                    r_reached <= src_ok ? (MAX_NODES'(1) << src_idx) : '0;
                    r_pass    <= '0;
                    r_eidx    <= '0;
                    r_neg     <= 1'b0;
                    r_idx     <= '0;
                end
                S_FETCH: begin
                    if (pass_end) begin
                        r_eidx <= '0;
                        if (!last_pass) begin
                            r_pass <= r_pass + CNTW'(1);
                        end
                    end
                end
                S_DIST: begin
                    if (skip) begin
                        r_eidx <= r_eidx + ETW'(1);
                    end
                end
                S_UPD: begin
                    if (improve) begin
                        if (last_pass) begin
                            r_neg <= 1'b1;
                        end else begin
                            r_reached[head_idx] <= 1'b1;
                        end
                    end
                    r_eidx <= r_eidx + ETW'(1);
                end
                S_EMIT: begin
                    r_idx <= r_idx + NIW'(1);
                    if (idx_last) begin
                        r_edge_total <= '0;
                        r_overflow   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // edge table
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[r_edge_total[EIW-1:0]] <= edge_wdata;
        end
        r_edge_rd <= edge_mem[r_eidx[EIW-1:0]];
    end

    // distance table
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD) && improve && !last_pass) begin
            dist_mem[head_idx] <= cand;
        end else if ((r_state == S_INIT) && src_ok) begin
            dist_mem[src_idx] <= '0;
        end
        if (rd_en) begin
            r_dist_a <= dist_mem[rd_a_addr];
            r_dist_b <= dist_mem[head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rev_edge <= '{tail: i_to_node, head: i_from_node, weight: i_weight};
            r_rev_last <= i_last_edge;
        end
        if (r_state == S_EMIT) begin
            r_out_idx   <= r_idx;
            r_out_reach <= r_reached[r_idx];
            r_out_neg   <= r_neg;
            r_out_ovf   <= r_overflow;
            r_out_last  <= idx_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_node_index     = bfsp_pkg::NODE_W'(r_out_idx);
    assign o_distance       = r_out_reach ? r_dist_a : '0;
    assign o_reachable      = r_out_reach;
    assign o_negative_cycle = r_out_neg;
    assign o_edge_overflow  = r_out_ovf;
    assign o_last_node      = r_out_last;

endmodule

`default_nettype wire

// File: design/bfsp_relax.sv
`timescale 1ns / 1ps
`default_nettype none

module bfsp_relax (
    input  wire                                  i_clk,
    input  wire                                  i_load,
    input  wire bfsp_pkg::t_dist                 i_tail_dist,
    input  wire signed [bfsp_pkg::WEIGHT_W-1:0]  i_weight,
    input  wire bfsp_pkg::t_dist                 i_head_dist,
    input  wire                                  i_head_reached,
    output bfsp_pkg::t_dist                      o_cand,
    output logic                                 o_improve
);

    localparam int DW = bfsp_pkg::DIST_W;
    localparam int WW = bfsp_pkg::WEIGHT_W;

    localparam bfsp_pkg::t_dist DistMax = {1'b0, {(DW - 1){1'b1}}};
    localparam bfsp_pkg::t_dist DistMin = {1'b1, {(DW - 1){1'b0}}};

    logic [DW:0]     sum;
    bfsp_pkg::t_dist sat;
    bfsp_pkg::t_dist r_cand;
    bfsp_pkg::t_dist r_head_dist;
    logic            r_head_reached;

    // 33-bit sum, then clamp to the 32-bit signed range
    always_comb begin
        sum = {i_tail_dist[DW-1], i_tail_dist}
            + {{(DW + 1 - WW){i_weight[WW-1]}}, i_weight};
        if (sum[DW] != sum[DW-1]) begin
            sat = sum[DW] ? DistMin : DistMax;
        end else begin
            sat = bfsp_pkg::t_dist'(sum[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cand         <= sat;
            r_head_dist    <= i_head_dist;
            r_head_reached <= i_head_reached;
        end
    end

    assign o_cand    = r_cand;
    assign o_improve = !r_head_reached || (r_cand < r_head_dist);

endmodule

`default_nettype wire

// File: tb/sv/tb_bellman_ford_shortest_paths_unit.sv
`timescale 1ns / 1ps

module tb_bellman_ford_shortest_paths_unit;

    localparam int NODE_W       = bfsp_pkg::NODE_W;
    localparam int WEIGHT_W     = bfsp_pkg::WEIGHT_W;
    localparam int DIST_W       = bfsp_pkg::DIST_W;
    localparam int NODE_COUNT_W = bfsp_pkg::NODE_COUNT_W;
    localparam int CFG_IDX_W    = bfsp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = bfsp_pkg::CFG_DATA_W;

    localparam int NODES = bfsp_pkg::DEF_MAX_NODES;
    localparam int ARCS  = bfsp_pkg::DEF_MAX_EDGES;
    localparam longint LEN_MAX = 64'sd2147483647;
    localparam longint LEN_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [NODE_W-1:0]        node;
        logic signed [DIST_W-1:0] path_len;
        logic                     reach;
        logic                     neg;
        logic                     ovf;
        logic                     closing;
    } t_node_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [NODE_W-1:0]          i_from_node = '0;
    logic [NODE_W-1:0]          i_to_node = '0;
    logic signed [WEIGHT_W-1:0] i_weight = '0;
    logic                       i_undirected = 1'b0;
    logic                       i_last_edge = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_valid;
    logic [NODE_W-1:0]          o_node_index;
    logic signed [DIST_W-1:0]   o_distance;
    logic                       o_reachable;
    logic                       o_negative_cycle;
    logic                       o_edge_overflow;
    logic                       o_last_node;

    // shadow of the block state
    logic [NODE_W-1:0]          arc_tail [ARCS];
    logic [NODE_W-1:0]          arc_head [ARCS];
    logic signed [WEIGHT_W-1:0] arc_wt [ARCS];
    int unsigned                arc_total;
    bit                         arc_dropped;
    longint                     best_len [NODES];
    bit                         reached [NODES];
    logic [NODE_COUNT_W-1:0]    cfg_nodes;
    logic [NODE_W-1:0]          cfg_src;

    t_node_report node_reports[$];
    int unsigned  mismatches = 0;
    int unsigned  idle_pct = 0;

    bellman_ford_shortest_paths_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_from_node      (i_from_node),
        .i_to_node        (i_to_node),
        .i_weight         (i_weight),
        .i_undirected     (i_undirected),
        .i_last_edge      (i_last_edge),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_node_index     (o_node_index),
        .o_distance       (o_distance),
        .o_reachable      (o_reachable),
        .o_negative_cycle (o_negative_cycle),
        .o_edge_overflow  (o_edge_overflow),
        .o_last_node      (o_last_node)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_bellman_ford_shortest_paths_unit: errors");
        $finish;
    end

    function automatic int unsigned nodes_in_use();
        int unsigned n;
        n = cfg_nodes;
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    function automatic void store_arc(input logic [NODE_W-1:0] tail,
                                      input logic [NODE_W-1:0] head,
                                      input logic signed [WEIGHT_W-1:0] w);
        if (arc_total >= ARCS) begin
            arc_dropped = 1'b1;
            return;
        end
        arc_tail[arc_total] = tail;
        arc_head[arc_total] = head;
        arc_wt[arc_total]   = w;
        arc_total++;
    endfunction

    function automatic bit relax_sweep(input int unsigned n, input bit apply);
        bit     improved;
        longint cand;
        improved = 1'b0;
        for (int unsigned e = 0; e < arc_total; e++) begin
            if (arc_tail[e] >= n || arc_head[e] >= n || !reached[arc_tail[e]]) continue;
            cand = best_len[arc_tail[e]] + longint'(arc_wt[e]);
            if (cand > LEN_MAX) cand = LEN_MAX;
            if (cand < LEN_MIN) cand = LEN_MIN;
            if (!reached[arc_head[e]] || cand < best_len[arc_head[e]]) begin
                if (!apply) return 1'b1;
                improved = 1'b1;
                best_len[arc_head[e]] = cand;
                reached[arc_head[e]]  = 1'b1;
            end
        end
        return improved;
    endfunction

    function automatic void predict_arc(input logic [NODE_W-1:0] tail,
                                        input logic [NODE_W-1:0] head,
                                        input logic signed [WEIGHT_W-1:0] w,
                                        input logic both_ways,
                                        input logic closes);
        int unsigned  n;
        bit           neg;
        t_node_report r;
        n   = nodes_in_use();
        neg = 1'b0;
        if (tail < n && head < n) begin
            store_arc(tail, head, w);
            if (both_ways) store_arc(head, tail, w);
        end
        if (!closes) return;
        for (int i = 0; i < NODES; i++) reached[i] = 1'b0;
        if (cfg_src < n) begin
            best_len[cfg_src] = 0;
            reached[cfg_src]  = 1'b1;
            for (int unsigned p = 0; p + 1 < n; p++) void'(relax_sweep(n, 1'b1));
            neg = relax_sweep(n, 1'b0);
        end
        for (int unsigned i = 0; i < n; i++) begin
            r.node     = NODE_W'(i);
            r.path_len = reached[i] ? DIST_W'(best_len[i]) : '0;
            r.reach    = reached[i];
            r.neg      = neg;
            r.ovf      = arc_dropped;
            r.closing  = (i + 1 == n);
            node_reports.insert(node_reports.size(), r);
        end
        arc_total   = 0;
        arc_dropped = 1'b0;
    endfunction

    function automatic void check_field(input string what, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_node_report want;
        if (i_rst_n && o_valid) begin
            if (node_reports.size() == 0) begin
                $display("%0t: result for node %0d expected none actual one",
                         $time, o_node_index);
                mismatches++;
            end else begin
                want = node_reports.pop_front();
                check_field("node_index", want.node, o_node_index);
                check_field("distance", want.path_len, o_distance);
                check_field("reachable", want.reach, o_reachable);
                check_field("negative_cycle", want.neg, o_negative_cycle);
                check_field("edge_overflow", want.ovf, o_edge_overflow);
                check_field("last_node", want.closing, o_last_node);
            end
        end
    end

    task automatic send_arc(input logic [NODE_W-1:0] tail, input logic [NODE_W-1:0] head,
                            input logic signed [WEIGHT_W-1:0] w, input logic both_ways,
                            input logic closes);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_from_node  <= tail;
        i_to_node    <= head;
        i_weight     <= w;
        i_undirected <= both_ways;
        i_last_edge  <= closes;
        // busy only moves on a rising edge, so its value here holds up to the next one
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_arc(tail, head, w, both_ways, closes);
    endtask

    // wait for every pending result, then let the block go quiet
    task automatic settle;
        @(negedge i_clk);
        start <= 1'b0;
        while (node_reports.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (idx == bfsp_pkg::REG_NODE_COUNT) cfg_nodes = data;
        else cfg_src = data[NODE_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_graph(input logic [CFG_DATA_W-1:0] count_data,
                             input logic [CFG_DATA_W-1:0] src_data);
        settle();
        write_reg(bfsp_pkg::REG_NODE_COUNT, count_data);
        write_reg(bfsp_pkg::REG_SOURCE_NODE, src_data);
    endtask

    task automatic apply_reset;
        arc_total   = 0;
        arc_dropped = 1'b0;
        cfg_nodes   = bfsp_pkg::NODE_COUNT_RST;
        cfg_src     = bfsp_pkg::SOURCE_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_reset_registers;
        send_arc(5'd0, 5'd1, 16'sh7fff, 1'b0, 1'b0);
        send_arc(5'd1, 5'd2, 16'sh8000, 1'b0, 1'b0);
        send_arc(5'd3, 5'd4, 16'sd9, 1'b0, 1'b0);
        send_arc(5'd6, 5'd1, 16'sd1, 1'b0, 1'b0);
        send_arc(5'd2, 5'd3, 16'sh7fff, 1'b1, 1'b1);
    endtask

    task automatic test_negative_loop;
        set_graph(6'd3, 6'd0);
        send_arc(5'd0, 5'd1, 16'sd1, 1'b0, 1'b0);
        send_arc(5'd1, 5'd2, -16'sd3, 1'b0, 1'b0);
        send_arc(5'd2, 5'd1, 16'sd1, 1'b0, 1'b1);
    endtask

    task automatic test_node_count_limits;
        set_graph(6'd1, 6'd0);
        send_arc(5'd0, 5'd0, 16'sd7, 1'b0, 1'b1);
        set_graph(6'd0, 6'd0);
        send_arc(5'd0, 5'd0, -16'sd1, 1'b0, 1'b1);
        set_graph(6'd63, 6'd63);
        send_arc(5'd31, 5'd30, 16'sh7fff, 1'b1, 1'b0);
        send_arc(5'd30, 5'd0, 16'sh8000, 1'b0, 1'b0);
        send_arc(5'd5, 5'd31, 16'sd1, 1'b0, 1'b1);
        set_graph(6'd32, 6'd31);
        send_arc(5'd31, 5'd0, -16'sd5, 1'b0, 1'b1);
    endtask

    task automatic test_source_outside;
        set_graph(6'd4, 6'd10);
        send_arc(5'd0, 5'd1, 16'sd2, 1'b1, 1'b0);
        send_arc(5'd9, 5'd1, 16'sd2, 1'b0, 1'b1);
    endtask

    task automatic test_stale_arcs;
        set_graph(6'd8, 6'd0);
        send_arc(5'd0, 5'd6, 16'sd2, 1'b0, 1'b0);
        send_arc(5'd6, 5'd7, -16'sd5, 1'b0, 1'b0);
        settle();
        write_reg(bfsp_pkg::REG_NODE_COUNT, 6'd7);
        send_arc(5'd0, 5'd1, 16'sd4, 1'b0, 1'b1);
    endtask

    task automatic test_table_full;
        idle_pct = 6;
        set_graph(6'd4, 6'd0);
        for (int i = 0; i < ARCS / 2 - 1; i++)
            send_arc(NODE_W'($urandom_range(3)), NODE_W'($urandom_range(3)),
                     WEIGHT_W'($urandom_range(100)), 1'b1, 1'b0);
        send_arc(5'd0, 5'd1, WEIGHT_W'($urandom_range(100)), 1'b0, 1'b0);
        // forward half fits, reverse half is dropped
        send_arc(5'd2, 5'd3, WEIGHT_W'($urandom_range(100)), 1'b1, 1'b0);
        send_arc(5'd1, 5'd2, WEIGHT_W'($urandom_range(100)), 1'b0, 1'b1);
        send_arc(5'd0, 5'd3, 16'sd3, 1'b0, 1'b1);
    endtask

    task automatic test_random_graphs;
        int unsigned              sent;
        int unsigned              n;
        int unsigned              arcs;
        int unsigned              pick;
        logic [CFG_DATA_W-1:0]    count_data;
        logic [CFG_DATA_W-1:0]    src_data;
        logic [NODE_W-1:0]        tail;
        logic [NODE_W-1:0]        head;
        logic signed [WEIGHT_W-1:0] w;
        sent = 0;
        while (sent < 40) begin
            if (sent < 14) idle_pct = 0;
            else if (sent < 27) idle_pct = 49;
            else idle_pct = 6;
            pick = $urandom_range(9);
            if (pick == 0) count_data = CFG_DATA_W'($urandom_range(32, 63));
            else if (pick == 1) count_data = CFG_DATA_W'($urandom_range(1));
            else count_data = CFG_DATA_W'($urandom_range(2, 8));
            settle();
            write_reg(bfsp_pkg::REG_NODE_COUNT, count_data);
            n = nodes_in_use();
            if ($urandom_range(9) == 0) src_data = CFG_DATA_W'($urandom_range(31));
            else src_data = CFG_DATA_W'($urandom_range(n - 1));
            if ($urandom_range(3) == 0) src_data[CFG_DATA_W-1] = 1'b1;
            write_reg(bfsp_pkg::REG_SOURCE_NODE, src_data);
            arcs = $urandom_range(1, 6);
            for (int unsigned k = 0; k < arcs; k++) begin
                if ($urandom_range(9) == 0) begin
                    tail = NODE_W'($urandom_range(31));
                    head = NODE_W'($urandom_range(31));
                end else begin
                    tail = NODE_W'($urandom_range(n - 1));
                    head = NODE_W'($urandom_range(n - 1));
                end
                pick = $urandom_range(9);
                if (pick < 6) w = WEIGHT_W'($urandom_range(60));
                else if (pick < 8) w = WEIGHT_W'(-int'($urandom_range(1, 20)));
                else if (pick == 8) w = WEIGHT_W'($urandom);
                else w = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                send_arc(tail, head, w, $urandom_range(3) == 0, k + 1 == arcs);
            end
            sent += arcs;
        end
    endtask

    initial begin
        apply_reset();
        test_reset_registers();
        test_negative_loop();
        test_node_count_limits();
        test_source_outside();
        test_stale_arcs();
        test_table_full();
        test_random_graphs();
        @(negedge i_clk);
        start <= 1'b0;
        while (node_reports.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_bellman_ford_shortest_paths_unit: clean");
        end else begin
            $display("tb_bellman_ford_shortest_paths_unit: errors");
        end
        $finish;
    end

endmodule
